// ===== sv/dsca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsca_pkg
// Shared codes and command/status types for the deadline split allocator.
// ----------------------------------------------------------------------------
package dsca_pkg;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_TASK  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] ST_PLACED = 4'd0;
    localparam logic [3:0] ST_SPLIT1 = 4'd1;
    localparam logic [3:0] ST_SPLIT2 = 4'd2;
    localparam logic [3:0] ST_ZERO   = 4'd3;
    localparam logic [3:0] ST_DLEQ   = 4'd4;
    localparam logic [3:0] ST_NOCPU  = 4'd5;
    localparam logic [3:0] ST_LATE   = 4'd6;
    localparam logic [3:0] ST_REST   = 4'd7;
    localparam logic [3:0] ST_FULL   = 4'd8;
    localparam logic [3:0] ST_RUN    = 4'd9;
    localparam logic [3:0] ST_IDLE   = 4'd10;
    localparam logic [3:0] ST_BEGIN  = 4'd11;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat, clamp cpu count
        logic do_begin;  // clear queues, set times
        logic rd_cur;    // read head entry of scan cpu
        logic tick_upd;  // decrement/pop head of scan cpu
        logic tick_rep;  // emit report of scan cpu
        logic task_a;    // classify task, push first piece, emit
        logic task_b;    // push rest piece, emit
        logic scan_clr;  // scan cpu to zero
        logic scan_inc;  // advance scan cpu
    } dsca_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       scan_last;  // scan cpu is final cpu in use
        logic       split;      // current task is a successful split
    } dsca_sts_t;

endpackage
`default_nettype wire

// ===== sv/deadline_split_cpu_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_split_cpu_allocator_unit
// Wrap-around deadline task splitting over per-cpu run queues.
// ----------------------------------------------------------------------------
// One item at a time. A begin or task beat is captured and decoded, and its
// first result beat is then registered for output; a split task's second
// result follows once the first is taken. A tick beat makes two passes over
// the cpus in use through one memory read port: an update pass, which reads
// and updates each cpu's head entry, and a report pass, which reads each
// head entry again and presents one result beat per cpu. A result beat that
// is stalled holds the unit until it is taken.
// ----------------------------------------------------------------------------
module deadline_split_cpu_allocator_unit #(
    parameter int CPUS        = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] now,
    input  wire logic [7:0]  task_id,
    input  wire logic [31:0] exec_time,
    input  wire logic [31:0] deadline,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       cpu,
    output logic [7:0]       run_task,
    output logic [31:0]      start_at,
    output logic [31:0]      run_length,
    output logic [3:0]       status,
    output logic             last
);
    logic [4:0] cpus_in_use_reg;
    dsca_pkg::dsca_cmd_t cmd;
    dsca_pkg::dsca_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cpus_in_use_reg <= 5'd4;
        else if (cfg_we)
            cpus_in_use_reg <= cfg_data;
    end

    dsca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    dsca_datapath #(.CPUS(CPUS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cpus_in_use(cpus_in_use_reg),
        .opcode(opcode), .now(now), .task_id(task_id), .exec_time(exec_time),
        .deadline(deadline), .cmd(cmd), .sts(sts), .cpu(cpu),
        .run_task(run_task), .start_at(start_at), .run_length(run_length),
        .status(status), .last(last)
    );
endmodule
`default_nettype wire

// ===== sv/dsca_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsca_datapath
// Queue memories, per-cpu ring pointers, allocation arithmetic, result register.
// ----------------------------------------------------------------------------
module dsca_datapath #(
    parameter int CPUS        = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [4:0]          cpus_in_use,
    input  wire logic [1:0]          opcode,
    input  wire logic [31:0]         now,
    input  wire logic [7:0]          task_id,
    input  wire logic [31:0]         exec_time,
    input  wire logic [31:0]         deadline,
    input  wire dsca_pkg::dsca_cmd_t cmd,
    output dsca_pkg::dsca_sts_t      sts,
    output logic [3:0]               cpu,
    output logic [7:0]               run_task,
    output logic [31:0]              start_at,
    output logic [31:0]              run_length,
    output logic [3:0]               status,
    output logic                     last
);
    localparam int CW   = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int SW   = $clog2(QUEUE_DEPTH);
    localparam int AW   = CW + SW;
    localparam int NW   = $clog2(QUEUE_DEPTH + 1);
    localparam int MD   = 2 ** AW;
    localparam int CNW  = $clog2(CPUS + 1);

    logic [7:0]  mem_task  [MD];
    logic [31:0] mem_start [MD];
    logic [31:0] mem_rem   [MD];

    logic [SW-1:0] head_reg  [CPUS];
    logic [NW-1:0] count_reg [CPUS];
    logic [4:0]    cur_reg;
    logic [31:0]   fill_reg, round_reg;
    logic [CNW-1:0] n_reg;
    logic [CW-1:0] scan_reg;

    logic [1:0]  op_reg;
    logic [7:0]  tid_reg;
    logic [31:0] now_reg;
    logic [31:0] et_reg, dl_reg;

    logic [7:0]  rd_task_reg;
    logic [31:0] rd_start_reg, rd_rem_reg;

    logic [31:0] et2_reg, rest_start_reg;
    logic [CW-1:0] rest_cpu_reg;

    // task classification
    logic [32:0] end_sum;
    logic [31:0] et1, et2;
    logic [32:0] nf_sum;
    logic        nocpu, no_next, full_c, full_n, is_split;
    logic [CW-1:0] cc, cn;

    always_comb
    begin
        cc = cur_reg[CW-1:0];
        cn = CW'(cur_reg + 5'd1);
        end_sum = {1'b0, fill_reg} + {1'b0, et_reg};
        et1 = dl_reg - fill_reg;
        et2 = et_reg - et1;
        nf_sum = {1'b0, round_reg} + {1'b0, et2};
        nocpu = {3'd0, cur_reg} >= 8'(n_reg);
        no_next = ({3'd0, cur_reg} + 8'd1) >= 8'(n_reg);
        full_c = count_reg[cc] == NW'(QUEUE_DEPTH);
        full_n = no_next ? 1'b1 : (count_reg[cn] == NW'(QUEUE_DEPTH));
        is_split = !nocpu && et_reg != 32'd0 && fill_reg < dl_reg
            && end_sum > {1'b0, dl_reg} && !no_next && !full_c && !full_n;
    end

    assign sts.opcode    = op_reg;
    assign sts.scan_last = ({{(8-CW){1'b0}}, scan_reg} + 8'd1) == 8'(n_reg);
    assign sts.split     = is_split;

    logic [AW-1:0] rd_addr;
    assign rd_addr = {scan_reg, head_reg[scan_reg]};

    logic [SW-1:0] head_inc;
    assign head_inc = (head_reg[scan_reg] == SW'(QUEUE_DEPTH - 1)) ? '0
        : SW'(head_reg[scan_reg] + SW'(1));

    // memories
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_task;
    logic [31:0]   wr_start, wr_rem;
    logic [AW-1:0] a_addr, b_addr;
    logic [SW:0]   a_sum, b_sum;
    logic [SW-1:0] a_slot, b_slot;

    always_comb
    begin
        a_sum = (SW+1)'(head_reg[cc]) + (SW+1)'(count_reg[cc]);
        b_sum = (SW+1)'(head_reg[rest_cpu_reg]) + (SW+1)'(count_reg[rest_cpu_reg]);
        a_slot = (a_sum >= (SW+1)'(QUEUE_DEPTH))
            ? SW'(a_sum - (SW+1)'(QUEUE_DEPTH)) : a_sum[SW-1:0];
        b_slot = (b_sum >= (SW+1)'(QUEUE_DEPTH))
            ? SW'(b_sum - (SW+1)'(QUEUE_DEPTH)) : b_sum[SW-1:0];
        a_addr = {cc, a_slot};
        b_addr = {rest_cpu_reg, b_slot};
        wr_en = 1'b0;
        wr_addr = a_addr;
        wr_task = tid_reg;
        wr_start = fill_reg;
        wr_rem = et_reg;
        if (cmd.tick_upd)
        begin
            wr_en = count_reg[scan_reg] != '0;
            wr_addr = rd_addr;
            wr_task = rd_task_reg;
            wr_start = rd_start_reg;
            wr_rem = rd_rem_reg - 32'd1;
        end
        else if (cmd.task_a)
        begin
            wr_en = !nocpu && et_reg != 32'd0 && fill_reg < dl_reg && !full_c
                && (end_sum <= {1'b0, dl_reg} || is_split);
            wr_rem = is_split ? et1 : et_reg;
        end
        else if (cmd.task_b)
        begin
            wr_en = 1'b1;
            wr_addr = b_addr;
            wr_start = rest_start_reg;
            wr_rem = et2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_task[wr_addr]  <= wr_task;
            mem_start[wr_addr] <= wr_start;
            mem_rem[wr_addr]   <= wr_rem;
        end
        if (cmd.rd_cur)
        begin
            rd_task_reg  <= mem_task[rd_addr];
            rd_start_reg <= mem_start[rd_addr];
            rd_rem_reg   <= mem_rem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            tid_reg <= task_id;
            now_reg <= now;
            et_reg  <= exec_time;
            dl_reg  <= deadline;
        end
        if (cmd.task_a)
        begin
            et2_reg        <= et2;
            rest_start_reg <= round_reg;
            rest_cpu_reg   <= cn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CPUS; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            cur_reg   <= '0;
            fill_reg  <= '0;
            round_reg <= '0;
            n_reg     <= CNW'(1);
            scan_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (cpus_in_use == 5'd0)
                    n_reg <= CNW'(1);
                else if ({27'd0, cpus_in_use} > 32'(CPUS))
                    n_reg <= CNW'(CPUS);
                else
                    n_reg <= CNW'(cpus_in_use);
            end
            if (cmd.scan_clr)
                scan_reg <= '0;
            else if (cmd.scan_inc)
                scan_reg <= CW'(scan_reg + CW'(1));
            if (cmd.do_begin)
            begin
                for (int i = 0; i < CPUS; i++)
                begin
                    head_reg[i]  <= '0;
                    count_reg[i] <= '0;
                end
                cur_reg   <= '0;
                fill_reg  <= now_reg;
                round_reg <= now_reg;
            end
            if (cmd.tick_upd && count_reg[scan_reg] != '0 && rd_rem_reg == 32'd1)
            begin
                head_reg[scan_reg]  <= head_inc;
                count_reg[scan_reg] <= NW'(count_reg[scan_reg] - NW'(1));
            end
            if (cmd.task_a && wr_en)
            begin
                count_reg[cc] <= NW'(count_reg[cc] + NW'(1));
                if (is_split)
                begin
                    fill_reg <= nf_sum[32] ? 32'hFFFF_FFFF : nf_sum[31:0];
                    cur_reg  <= 5'(cur_reg + 5'd1);
                end
                else if (end_sum == {1'b0, dl_reg})
                begin
                    fill_reg <= round_reg;
                    cur_reg  <= 5'(cur_reg + 5'd1);
                end
                else
                    fill_reg <= end_sum[31:0];
            end
            if (cmd.task_a && !nocpu && et_reg != 32'd0 && fill_reg == dl_reg)
            begin
                fill_reg <= round_reg;
                cur_reg  <= 5'(cur_reg + 5'd1);
            end
            if (cmd.task_b)
                count_reg[rest_cpu_reg] <= NW'(count_reg[rest_cpu_reg] + NW'(1));
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.do_begin)
        begin
            cpu <= 4'd0; run_task <= 8'd0; start_at <= 32'd0; run_length <= 32'd0;
            status <= dsca_pkg::ST_BEGIN; last <= 1'b1;
        end
        else if (cmd.tick_rep)
        begin
            cpu  <= 4'(scan_reg);
            last <= sts.scan_last;
            if (count_reg[scan_reg] != '0)
            begin
                run_task <= rd_task_reg; start_at <= rd_start_reg;
                run_length <= rd_rem_reg; status <= dsca_pkg::ST_RUN;
            end
            else
            begin
                run_task <= 8'd0; start_at <= 32'd0; run_length <= 32'd0;
                status <= dsca_pkg::ST_IDLE;
            end
        end
        else if (cmd.task_a)
        begin
            cpu <= nocpu ? 4'd0 : cur_reg[3:0];
            run_task <= tid_reg;
            start_at <= 32'd0;
            run_length <= 32'd0;
            last <= !is_split;
            if (nocpu)
                status <= dsca_pkg::ST_NOCPU;
            else if (et_reg == 32'd0)
                status <= dsca_pkg::ST_ZERO;
            else if (fill_reg < dl_reg)
            begin
                if (end_sum > {1'b0, dl_reg})
                begin
                    if (no_next)
                        status <= dsca_pkg::ST_REST;
                    else if (full_c || full_n)
                        status <= dsca_pkg::ST_FULL;
                    else
                    begin
                        status <= dsca_pkg::ST_SPLIT1;
                        start_at <= fill_reg;
                        run_length <= et1;
                    end
                end
                else if (full_c)
                    status <= dsca_pkg::ST_FULL;
                else
                begin
                    status <= dsca_pkg::ST_PLACED;
                    start_at <= fill_reg;
                    run_length <= et_reg;
                end
            end
            else if (fill_reg == dl_reg)
                status <= dsca_pkg::ST_DLEQ;
            else
                status <= dsca_pkg::ST_LATE;
        end
        else if (cmd.task_b)
        begin
            cpu <= 4'(rest_cpu_reg); run_task <= tid_reg;
            start_at <= rest_start_reg; run_length <= et2_reg;
            status <= dsca_pkg::ST_SPLIT2; last <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== sv/dsca_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsca_ctrl
// Sequencer: accepts beats, steps datapath, presents result beats.
// ----------------------------------------------------------------------------
module dsca_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  wire logic                out_stall,
    input  wire dsca_pkg::dsca_sts_t sts,
    output dsca_pkg::dsca_cmd_t      cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_REP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic [1:0] after_reg, after_next;   // 0 done, 1 task_b, 2 next report
    logic       pass_reg, pass_next;     // tick: 0 update pass, 1 report pass

    localparam logic [1:0] A_DONE = 2'd0;
    localparam logic [1:0] A_B    = 2'd1;
    localparam logic [1:0] A_REP  = 2'd2;

    logic out_take;
    assign out_take = ov_reg && !out_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = out_take ? 1'b0 : ov_reg;
        after_next = after_reg;
        pass_next = pass_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!ov_reg || out_take)
                begin
                    case (sts.opcode)
                        dsca_pkg::OP_BEGIN:
                        begin
                            cmd.do_begin = 1'b1; ov_next = 1'b1;
                            after_next = A_DONE; state_next = S_OUT;
                        end
                        dsca_pkg::OP_TASK:
                        begin
                            cmd.task_a = 1'b1; ov_next = 1'b1;
                            after_next = sts.split ? A_B : A_DONE;
                            state_next = S_OUT;
                        end
                        dsca_pkg::OP_TICK:
                        begin
                            cmd.scan_clr = 1'b1; pass_next = 1'b0;
                            state_next = S_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RD:
            begin
                cmd.rd_cur = 1'b1;
                state_next = pass_reg ? S_REP : S_UPD;
            end
            S_UPD:
            begin
                cmd.tick_upd = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.scan_clr = 1'b1; pass_next = 1'b1;
                end
                else
                    cmd.scan_inc = 1'b1;
                state_next = S_RD;
            end
            S_REP:
            begin
                if (!ov_reg || out_take)
                begin
                    cmd.tick_rep = 1'b1; ov_next = 1'b1;
                    after_next = sts.scan_last ? A_DONE : A_REP;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_take)
                begin
                    unique case (after_reg)
                        A_B:
                        begin
                            cmd.task_b = 1'b1; ov_next = 1'b1;
                            after_next = A_DONE;
                        end
                        A_REP:
                        begin
                            cmd.scan_inc = 1'b1; state_next = S_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            after_reg <= A_DONE;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            after_reg <= after_next;
            pass_reg  <= pass_next;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg)
        else $error("result beat dropped under stall");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> ov_reg)
        else $error("output state without result");
endmodule
`default_nettype wire
